### design/mbrhs_pkg.sv
// shared types and constants for the function 03 holding register slave
`timescale 1ns / 1ps

package mbrhs_pkg;

  // modbus codes
  localparam logic [7:0] FC_READ_HOLDING      = 8'h03;
  localparam logic [7:0] EXC_FLAG             = 8'h80;
  localparam logic [7:0] EXC_ILLEGAL_FUNCTION = 8'h01;
  localparam logic [7:0] EXC_ILLEGAL_ADDRESS  = 8'h02;
  localparam logic [7:0] EXC_ILLEGAL_VALUE    = 8'h03;
  localparam logic [7:0] READ_DATA_LEN        = 8'd4;
  localparam logic [7:0] SLAVE_ADDR_RST       = 8'h01;

  // input kinds
  localparam logic KIND_LOAD    = 1'b0;
  localparam logic KIND_REQUEST = 1'b1;

  // shared adder / comparator width, covers a 16-bit address plus a count
  localparam int unsigned ALU_W = 17;
  // remaining register count, quantity is at most 125
  localparam int unsigned CNT_W = 7;

  typedef enum logic [1:0] {
    ITEM_HDR  = 2'd0,
    ITEM_DATA = 2'd1,
    ITEM_EXC  = 2'd2
  } item_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_LD_ADD,
    ST_LD_CHK,
    ST_LD_GROW,
    ST_RQ_END,
    ST_RQ_CHK,
    ST_EXC,
    ST_HDR,
    ST_RD1,
    ST_RD2,
    ST_RD3,
    ST_DATA
  } st_e;

  typedef struct packed {
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [ALU_W-1:0] sum;
    logic             lt;
  } alu_rsp_t;

endpackage

### design/mbrhs_ram.sv
// generic simple dual port ram with registered read
`timescale 1ns / 1ps

module mbrhs_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/mbrhs_alu.sv
// shared adder and unsigned less-than unit used by the sequencer
`timescale 1ns / 1ps

module mbrhs_alu import mbrhs_pkg::*; (
  input  alu_req_t req_i,
  output alu_rsp_t rsp_o
);

  // one add and one compare per cycle
  assign rsp_o.sum = req_i.a + req_i.b;
  assign rsp_o.lt  = (req_i.a < req_i.b);

endmodule

### design/modbus_read_holding_slave.sv
// function 03 holding register slave: sequencer, store and reply output register
// load: add, check and grow states between accepts, with the grow state skipped for a write past the store;
// request with no data: decode, then range checks if reached, and an exception item if one is due;
// good request: header, then each register pair read on the single store read port, plus output back-pressure
// reset: asynchronous, active low; a clearing pass then zeroes the store
// while in_ready_o stays low (configuration writes are taken)
`timescale 1ns / 1ps

module modbus_read_holding_slave import mbrhs_pkg::*; #(
  parameter int unsigned REG_DEPTH    = 1024,
  parameter int unsigned MAX_QUANTITY = 125
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_slave_address_i,
  // input items
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic [15:0] reg_address_i,
  input  logic [15:0] reg_value_i,
  input  logic [7:0]  frame_address_i,
  input  logic [7:0]  function_code_i,
  input  logic [7:0]  data_length_i,
  input  logic [15:0] start_address_i,
  input  logic [15:0] quantity_i,
  // result items
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  response_address_o,
  output logic [7:0]  response_function_o,
  output logic [1:0]  item_type_o,
  output logic [7:0]  header_value_o,
  output logic [15:0] first_register_o,
  output logic [15:0] second_register_o,
  output logic        second_valid_o,
  output logic        last_o
);

  localparam int unsigned AW = (REG_DEPTH > 1) ? $clog2(REG_DEPTH) : 1;
  localparam int unsigned UW = $clog2(REG_DEPTH + 1);

  // control state
  st_e           state_q, state_d;
  logic [7:0]    slave_addr_q, slave_addr_d;
  logic [UW-1:0] used_size_q, used_size_d;
  logic [AW-1:0] clr_cnt_q, clr_cnt_d;
  logic          out_valid_q, out_valid_d;

  // request payload and working registers
  logic [15:0]      reg_addr_q, reg_addr_d;
  logic [15:0]      reg_val_q, reg_val_d;
  logic [7:0]       faddr_q, faddr_d;
  logic [7:0]       fc_q, fc_d;
  logic [7:0]       dlen_q, dlen_d;
  logic [15:0]      start_q, start_d;
  logic [15:0]      qty_q, qty_d;
  logic [ALU_W-1:0] tmp_q, tmp_d;
  logic [ALU_W-1:0] ptr_q, ptr_d;
  logic [CNT_W-1:0] rem_q, rem_d;
  logic [7:0]       exc_q, exc_d;
  logic [15:0]      r1_q, r1_d;
  logic [15:0]      r2_q, r2_d;

  // output register
  logic [7:0]  o_addr_q, o_addr_d;
  logic [7:0]  o_fn_q, o_fn_d;
  item_e       o_type_q, o_type_d;
  logic [7:0]  o_hv_q, o_hv_d;
  logic [15:0] o_r1_q, o_r1_d;
  logic [15:0] o_r2_q, o_r2_d;
  logic        o_sv_q, o_sv_d;
  logic        o_last_q, o_last_d;

  // store ports and shared unit
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [15:0]   ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [15:0]   ram_rdata;
  alu_req_t      alu_req;
  alu_rsp_t      alu_rsp;

  logic slot_free;
  logic in_acc;

  mbrhs_ram #(
    .WIDTH (16),
    .DEPTH (REG_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  mbrhs_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign slot_free   = !out_valid_q || out_ready_i;

  // sequencer: next state, shared unit operands, store access, output load
  always_comb begin
    state_d      = state_q;
    slave_addr_d = cfg_valid_i ? cfg_slave_address_i : slave_addr_q;
    used_size_d  = used_size_q;
    clr_cnt_d    = clr_cnt_q;
    out_valid_d  = out_valid_q && !out_ready_i;

    reg_addr_d = reg_addr_q;
    reg_val_d  = reg_val_q;
    faddr_d    = faddr_q;
    fc_d       = fc_q;
    dlen_d     = dlen_q;
    start_d    = start_q;
    qty_d      = qty_q;
    tmp_d      = tmp_q;
    ptr_d      = ptr_q;
    rem_d      = rem_q;
    exc_d      = exc_q;
    r1_d       = r1_q;
    r2_d       = r2_q;

    o_addr_d = o_addr_q;
    o_fn_d   = o_fn_q;
    o_type_d = o_type_q;
    o_hv_d   = o_hv_q;
    o_r1_d   = o_r1_q;
    o_r2_d   = o_r2_q;
    o_sv_d   = o_sv_q;
    o_last_d = o_last_q;

    ram_we    = 1'b0;
    ram_waddr = reg_addr_q[AW-1:0];
    ram_wdata = reg_val_q;
    ram_re    = 1'b0;
    ram_raddr = ptr_q[AW-1:0];
    alu_req.a = ptr_q;
    alu_req.b = ALU_W'(1);

    case (state_q)
      // zero the store one word a cycle
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_q;
        ram_wdata = '0;
        clr_cnt_d = clr_cnt_q + AW'(1);
        if (clr_cnt_q == AW'(REG_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      // take the next request
      ST_IDLE: begin
        if (in_acc) begin
          reg_addr_d = reg_address_i;
          reg_val_d  = reg_value_i;
          faddr_d    = frame_address_i;
          fc_d       = function_code_i;
          dlen_d     = data_length_i;
          start_d    = start_address_i;
          qty_d      = quantity_i;
          state_d    = (kind_i == KIND_LOAD) ? ST_LD_ADD : ST_DECODE;
        end
      end
      // load: end address of the written word
      ST_LD_ADD: begin
        alu_req.a = ALU_W'(reg_addr_q);
        alu_req.b = ALU_W'(1);
        tmp_d     = alu_rsp.sum;
        state_d   = ST_LD_CHK;
      end
      // load: drop writes beyond the store
      ST_LD_CHK: begin
        alu_req.a = ALU_W'(REG_DEPTH);
        alu_req.b = tmp_q;
        if (alu_rsp.lt) begin
          state_d = ST_IDLE;
        end else begin
          ram_we  = 1'b1;
          state_d = ST_LD_GROW;
        end
      end
      // load: grow the used size
      ST_LD_GROW: begin
        alu_req.a = ALU_W'(used_size_q);
        alu_req.b = tmp_q;
        if (alu_rsp.lt) begin
          used_size_d = tmp_q[UW-1:0];
        end
        state_d = ST_IDLE;
      end
      // request: address, function and format checks
      ST_DECODE: begin
        if (faddr_q != slave_addr_q) begin
          state_d = ST_IDLE;
        end else if (fc_q != FC_READ_HOLDING) begin
          exc_d   = EXC_ILLEGAL_FUNCTION;
          state_d = ST_EXC;
        end else if (dlen_q != READ_DATA_LEN || qty_q == '0 ||
                     qty_q > 16'(MAX_QUANTITY)) begin
          exc_d   = EXC_ILLEGAL_VALUE;
          state_d = ST_EXC;
        end else begin
          state_d = ST_RQ_END;
        end
      end
      // request: end of the range
      ST_RQ_END: begin
        alu_req.a = ALU_W'(start_q);
        alu_req.b = ALU_W'(qty_q);
        tmp_d     = alu_rsp.sum;
        ptr_d     = ALU_W'(start_q);
        rem_d     = qty_q[CNT_W-1:0];
        state_d   = ST_RQ_CHK;
      end
      // request: range must lie within the used size
      ST_RQ_CHK: begin
        alu_req.a = ALU_W'(used_size_q);
        alu_req.b = tmp_q;
        if (alu_rsp.lt) begin
          exc_d   = EXC_ILLEGAL_ADDRESS;
          state_d = ST_EXC;
        end else begin
          state_d = ST_HDR;
        end
      end
      // exception reply
      ST_EXC: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          o_addr_d    = slave_addr_q;
          o_fn_d      = fc_q | EXC_FLAG;
          o_type_d    = ITEM_EXC;
          o_hv_d      = exc_q;
          o_r1_d      = '0;
          o_r2_d      = '0;
          o_sv_d      = 1'b0;
          o_last_d    = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      // header with the byte count
      ST_HDR: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          o_addr_d    = slave_addr_q;
          o_fn_d      = FC_READ_HOLDING;
          o_type_d    = ITEM_HDR;
          o_hv_d      = {rem_q, 1'b0};
          o_r1_d      = '0;
          o_r2_d      = '0;
          o_sv_d      = 1'b0;
          o_last_d    = 1'b0;
          state_d     = ST_RD1;
        end
      end
      // read the first word of a pair
      ST_RD1: begin
        ram_re  = 1'b1;
        ptr_d   = alu_rsp.sum;
        state_d = ST_RD2;
      end
      // capture the first word, read the second if any
      ST_RD2: begin
        r1_d = ram_rdata;
        if (rem_q >= CNT_W'(2)) begin
          ram_re  = 1'b1;
          ptr_d   = alu_rsp.sum;
          state_d = ST_RD3;
        end else begin
          r2_d    = '0;
          state_d = ST_DATA;
        end
      end
      // capture the second word
      ST_RD3: begin
        r2_d    = ram_rdata;
        state_d = ST_DATA;
      end
      // register pair
      ST_DATA: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          o_addr_d    = slave_addr_q;
          o_fn_d      = FC_READ_HOLDING;
          o_type_d    = ITEM_DATA;
          o_hv_d      = '0;
          o_r1_d      = r1_q;
          o_r2_d      = r2_q;
          o_sv_d      = (rem_q >= CNT_W'(2));
          o_last_d    = (rem_q <= CNT_W'(2));
          rem_d       = (rem_q >= CNT_W'(2)) ? rem_q - CNT_W'(2) : '0;
          state_d     = (rem_q <= CNT_W'(2)) ? ST_IDLE : ST_RD1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      slave_addr_q <= SLAVE_ADDR_RST;
      used_size_q  <= '0;
      clr_cnt_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      slave_addr_q <= slave_addr_d;
      used_size_q  <= used_size_d;
      clr_cnt_q    <= clr_cnt_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    reg_addr_q <= reg_addr_d;
    reg_val_q  <= reg_val_d;
    faddr_q    <= faddr_d;
    fc_q       <= fc_d;
    dlen_q     <= dlen_d;
    start_q    <= start_d;
    qty_q      <= qty_d;
    tmp_q      <= tmp_d;
    ptr_q      <= ptr_d;
    rem_q      <= rem_d;
    exc_q      <= exc_d;
    r1_q       <= r1_d;
    r2_q       <= r2_d;
    o_addr_q   <= o_addr_d;
    o_fn_q     <= o_fn_d;
    o_type_q   <= o_type_d;
    o_hv_q     <= o_hv_d;
    o_r1_q     <= o_r1_d;
    o_r2_q     <= o_r2_d;
    o_sv_q     <= o_sv_d;
    o_last_q   <= o_last_d;
  end

  // result outputs
  assign out_valid_o         = out_valid_q;
  assign response_address_o  = o_addr_q;
  assign response_function_o = o_fn_q;
  assign item_type_o         = o_type_q;
  assign header_value_o      = o_hv_q;
  assign first_register_o    = o_r1_q;
  assign second_register_o   = o_r2_q;
  assign second_valid_o      = o_sv_q;
  assign last_o              = o_last_q;

`ifndef NO_ASSERTIONS
  // used size never passes the store depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ALU_W'(used_size_q) <= ALU_W'(REG_DEPTH))
    else $error("used size beyond store depth");

  // a request is worked on alone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_o)
    else $error("request taken while busy");

  // the first read of a pair lies inside the used size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RD1) |-> (ptr_q < ALU_W'(used_size_q)))
    else $error("read pointer outside used size");

  // an exception is a reply of its own
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && item_type_o == ITEM_EXC) |-> last_o)
    else $error("exception item not last");

  // a data item never leaves before the pair has been read
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DATA) |-> ($past(state_q) == ST_RD2 || $past(state_q) == ST_RD3 ||
                              $past(state_q) == ST_DATA))
    else $error("data item without store read");
`endif

endmodule

### tb/modbus_read_holding_slave_tb.sv
// testbench for the function 03 holding register slave: random and directed requests vs. a predictor
`timescale 1ns / 1ps

module modbus_read_holding_slave_tb import mbrhs_pkg::*;;

  localparam int unsigned DEPTH    = 1024;
  localparam int unsigned MAXQ     = 125;
  localparam int unsigned SETTLE   = 20;
  localparam int unsigned WD_LIMIT = 5000;

  // one input item as the block sees it
  typedef struct {
    logic        kind;
    logic [15:0] reg_address;
    logic [15:0] reg_value;
    logic [7:0]  frame_address;
    logic [7:0]  function_code;
    logic [7:0]  data_length;
    logic [15:0] start_address;
    logic [15:0] quantity;
  } frame_t;

  // one item of a reply
  typedef struct {
    logic [7:0]  address;
    logic [7:0]  func;
    logic [1:0]  kind;
    logic [7:0]  hval;
    logic [15:0] first_reg;
    logic [15:0] second_reg;
    logic        second_ok;
    logic        last;
  } reply_t;

  // holding register store model and queue of reply items still to come
  class holding_scoreboard;
    logic [15:0] regs [DEPTH];
    int unsigned used;
    logic [7:0]  slave_addr;
    reply_t      replies [$];
    int unsigned errors;

    function new();
      foreach (regs[i]) regs[i] = '0;
      used       = 0;
      slave_addr = SLAVE_ADDR_RST;
      errors     = 0;
    endfunction

    function void set_slave_address(logic [7:0] a);
      slave_addr = a;
    endfunction

    function int unsigned pending();
      return replies.size();
    endfunction

    // append one reply item at the tail
    function void queue_reply(reply_t r);
      replies.insert(replies.size(), r);
    endfunction

    function void add_exception(logic [7:0] fc, logic [7:0] code);
      reply_t r;
      r.address    = slave_addr;
      r.func       = fc | EXC_FLAG;
      r.kind       = ITEM_EXC;
      r.hval       = code;
      r.first_reg  = '0;
      r.second_reg = '0;
      r.second_ok  = 1'b0;
      r.last       = 1'b1;
      queue_reply(r);
    endfunction

    // update the store or work out the reply of one accepted item
    function void note_item(frame_t f);
      int unsigned addr, start, count, off;
      reply_t r;
      if (f.kind == KIND_LOAD) begin
        addr = f.reg_address;
        if (addr < DEPTH) begin
          regs[addr] = f.reg_value;
          if (addr + 1 > used) used = addr + 1;
        end
        return;
      end
      // not addressed to us, broadcast included
      if (f.frame_address != slave_addr) return;
      if (f.function_code != FC_READ_HOLDING) begin
        add_exception(f.function_code, EXC_ILLEGAL_FUNCTION);
        return;
      end
      start = f.start_address;
      count = f.quantity;
      if (f.data_length != READ_DATA_LEN || count < 1 || count > MAXQ) begin
        add_exception(f.function_code, EXC_ILLEGAL_VALUE);
        return;
      end
      if (start >= used || start + count > used) begin
        add_exception(f.function_code, EXC_ILLEGAL_ADDRESS);
        return;
      end
      // header with byte count, then register pairs
      r.address    = slave_addr;
      r.func       = FC_READ_HOLDING;
      r.kind       = ITEM_HDR;
      r.hval       = 8'(2 * count);
      r.first_reg  = '0;
      r.second_reg = '0;
      r.second_ok  = 1'b0;
      r.last       = 1'b0;
      queue_reply(r);
      for (off = 0; off < count; off += 2) begin
        r.kind       = ITEM_DATA;
        r.hval       = '0;
        r.first_reg  = regs[start + off];
        r.second_ok  = (off + 1 < count);
        r.second_reg = r.second_ok ? regs[start + off + 1] : 16'h0;
        r.last       = (off + 2 >= count);
        queue_reply(r);
      end
    endfunction

    function void diff(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", field, want, got);
        errors++;
      end
    endfunction

    // compare one reply item with the oldest expectation
    function void check_result(reply_t got);
      reply_t want;
      if (replies.size() == 0) begin
        $error("reply item with none expected, function %0h type %0d", got.func, got.kind);
        errors++;
        return;
      end
      want = replies.pop_front();
      diff("response_address", 16'(want.address), 16'(got.address));
      diff("response_function", 16'(want.func), 16'(got.func));
      diff("item_type", 16'(want.kind), 16'(got.kind));
      diff("header_value", 16'(want.hval), 16'(got.hval));
      diff("first_register", want.first_reg, got.first_reg);
      diff("second_register", want.second_reg, got.second_reg);
      diff("second_valid", 16'(want.second_ok), 16'(got.second_ok));
      diff("last", 16'(want.last), 16'(got.last));
    endfunction
  endclass

  logic clk;
  logic rst_n = 1'b0;

  logic        cfg_valid = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_data  = '0;

  logic        in_valid  = 1'b0;
  logic        in_ready_o;
  logic        kind      = 1'b0;
  logic [15:0] reg_address   = '0;
  logic [15:0] reg_value     = '0;
  logic [7:0]  frame_address = '0;
  logic [7:0]  function_code = '0;
  logic [7:0]  data_length   = '0;
  logic [15:0] start_address = '0;
  logic [15:0] quantity      = '0;

  logic        out_valid_o;
  logic        out_ready = 1'b0;
  logic [7:0]  response_address_o;
  logic [7:0]  response_function_o;
  logic [1:0]  item_type_o;
  logic [7:0]  header_value_o;
  logic [15:0] first_register_o;
  logic [15:0] second_register_o;
  logic        second_valid_o;
  logic        last_o;

  holding_scoreboard sb = new();
  bit          idle_on    = 1'b1;
  int unsigned stall_left = 0;
  int unsigned quiet      = 0;

  modbus_read_holding_slave #(
    .REG_DEPTH    (DEPTH),
    .MAX_QUANTITY (MAXQ)
  ) u_dut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .cfg_valid_i         (cfg_valid),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_slave_address_i (cfg_data),
    .in_valid_i          (in_valid),
    .in_ready_o          (in_ready_o),
    .kind_i              (kind),
    .reg_address_i       (reg_address),
    .reg_value_i         (reg_value),
    .frame_address_i     (frame_address),
    .function_code_i     (function_code),
    .data_length_i       (data_length),
    .start_address_i     (start_address),
    .quantity_i          (quantity),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready),
    .response_address_o  (response_address_o),
    .response_function_o (response_function_o),
    .item_type_o         (item_type_o),
    .header_value_o      (header_value_o),
    .first_register_o    (first_register_o),
    .second_register_o   (second_register_o),
    .second_valid_o      (second_valid_o),
    .last_o              (last_o)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // reply monitor and random back-pressure
  always @(posedge clk) begin : reply_side
    reply_t got;
    if (out_valid_o && out_ready) begin
      got.address    = response_address_o;
      got.func       = response_function_o;
      got.kind       = item_type_o;
      got.hval       = header_value_o;
      got.first_reg  = first_register_o;
      got.second_reg = second_register_o;
      got.second_ok  = second_valid_o;
      got.last       = last_o;
      sb.check_result(got);
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 3);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready) || (cfg_valid && cfg_ready_o))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= WD_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic frame_t random_frame();
    frame_t f;
    f.kind          = 1'($urandom_range(0, 1));
    f.reg_address   = 16'($urandom_range(0, 16'hFFFF));
    f.reg_value     = 16'($urandom_range(0, 16'hFFFF));
    f.frame_address = 8'($urandom_range(0, 255));
    f.function_code = 8'($urandom_range(0, 255));
    f.data_length   = 8'($urandom_range(0, 252));
    f.start_address = 16'($urandom_range(0, 16'hFFFF));
    f.quantity      = 16'($urandom_range(0, 16'hFFFF));
    return f;
  endfunction

  function automatic frame_t mk_load(logic [15:0] addr, logic [15:0] val);
    frame_t f;
    f             = random_frame();
    f.kind        = KIND_LOAD;
    f.reg_address = addr;
    f.reg_value   = val;
    return f;
  endfunction

  function automatic frame_t mk_req(logic [7:0] fa, logic [7:0] fc, logic [7:0] dl,
                                    logic [15:0] start, logic [15:0] qty);
    frame_t f;
    f               = random_frame();
    f.kind          = KIND_REQUEST;
    f.frame_address = fa;
    f.function_code = fc;
    f.data_length   = dl;
    f.start_address = start;
    f.quantity      = qty;
    return f;
  endfunction

  // offer one item, optionally after an idle burst, and wait for acceptance
  task automatic send_item(input frame_t f);
    int unsigned gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    kind          <= f.kind;
    reg_address   <= f.reg_address;
    reg_value     <= f.reg_value;
    frame_address <= f.frame_address;
    function_code <= f.function_code;
    data_length   <= f.data_length;
    start_address <= f.start_address;
    quantity      <= f.quantity;
    @(posedge clk);
    while (!in_ready_o) @(posedge clk);
    sb.note_item(f);
  endtask

  // let every pending reply drain, then give the block time to settle
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_slave_address(input logic [7:0] a);
    cfg_valid <= 1'b1;
    cfg_data  <= a;
    @(posedge clk);
    while (!cfg_ready_o) @(posedge clk);
    sb.set_slave_address(a);
    cfg_valid <= 1'b0;
  endtask

  // mostly well-formed reads over the used range, plus loads and broken requests
  task automatic random_phase(input int unsigned n);
    int unsigned counted, pick, qty, top, start;
    frame_t f;
    counted = 0;
    while (counted < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        top = (sb.used + 48 > DEPTH - 1) ? DEPTH - 1 : sb.used + 48;
        f   = mk_load(16'($urandom_range(0, top)), 16'($urandom_range(0, 16'hFFFF)));
      end else if (pick < 40) begin
        f = mk_load(16'($urandom_range(0, 16'hFFFF)), 16'($urandom_range(0, 16'hFFFF)));
      end else begin
        qty = ($urandom_range(0, 15) == 0) ? $urandom_range(1, MAXQ) : $urandom_range(1, 8);
        if (qty > sb.used)
          start = $urandom_range(0, sb.used);
        else if ($urandom_range(0, 7) == 0)
          start = $urandom_range(sb.used - qty, sb.used);
        else
          start = $urandom_range(0, sb.used - qty);
        f = mk_req(sb.slave_addr, FC_READ_HOLDING, READ_DATA_LEN, 16'(start), 16'(qty));
        // broken requests: one field spoiled
        if (pick >= 85) begin
          case ($urandom_range(0, 4))
            0: f.frame_address = 8'($urandom_range(0, 255));
            1: f.function_code = 8'($urandom_range(0, 255));
            2: f.data_length   = 8'($urandom_range(0, 252));
            3: f.quantity      = 16'($urandom_range(0, 16'hFFFF));
            default: f.start_address = 16'($urandom_range(0, 16'hFFFF));
          endcase
        end
      end
      if ((f.kind == KIND_LOAD && f.reg_address < DEPTH) ||
          (f.kind == KIND_REQUEST && f.frame_address == sb.slave_addr))
        counted++;
      send_item(f);
    end
  endtask

  // main sequence
  initial begin
    logic [7:0] sa;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed part at the reset slave address
    sa = SLAVE_ADDR_RST;
    send_item(mk_req(sa, FC_READ_HOLDING, READ_DATA_LEN, 16'd0, 16'd1));  // empty store
    send_item(mk_load(16'd9, 16'hFFFF));
    send_item(mk_load(16'd2, 16'h8001));
    send_item(mk_load(16'd1024, 16'h1234));                                // past the store
    send_item(mk_load(16'hFFFF, 16'h0000));
    send_item(mk_req(sa, FC_READ_HOLDING, READ_DATA_LEN, 16'd8, 16'd2));
    send_item(mk_req(sa, FC_READ_HOLDING, READ_DATA_LEN, 16'd8, 16'd3));   // end past used size
    send_item(mk_req(sa, FC_READ_HOLDING, READ_DATA_LEN, 16'd10, 16'd1));  // start at used size
    send_item(mk_req(sa, FC_READ_HOLDING, READ_DATA_LEN, 16'd0, 16'd10));  // gaps read zero
    send_item(mk_req(8'h02, FC_READ_HOLDING, READ_DATA_LEN, 16'd0, 16'd1)); // other slave
    send_item(mk_req(8'h00, FC_READ_HOLDING, READ_DATA_LEN, 16'd0, 16'd1)); // broadcast
    send_item(mk_req(sa, 8'h00, READ_DATA_LEN, 16'd0, 16'd1));
    send_item(mk_req(sa, 8'hFF, READ_DATA_LEN, 16'd0, 16'd1));
    send_item(mk_req(sa, 8'h04, READ_DATA_LEN, 16'd0, 16'd1));
    send_item(mk_req(sa, FC_READ_HOLDING, 8'd0, 16'd0, 16'd1));
    send_item(mk_req(sa, FC_READ_HOLDING, 8'd252, 16'd0, 16'd1));
    send_item(mk_req(sa, FC_READ_HOLDING, 8'd5, 16'd0, 16'd1));
    send_item(mk_req(sa, FC_READ_HOLDING, READ_DATA_LEN, 16'd0, 16'd0));
    send_item(mk_req(sa, FC_READ_HOLDING, READ_DATA_LEN, 16'd0, 16'd126));
    send_item(mk_req(sa, FC_READ_HOLDING, READ_DATA_LEN, 16'd0, 16'hFFFF));
    send_item(mk_load(16'd124, 16'h7FFE));
    send_item(mk_req(sa, FC_READ_HOLDING, READ_DATA_LEN, 16'd0, 16'd125));   // longest reply
    send_item(mk_req(sa, FC_READ_HOLDING, READ_DATA_LEN, 16'd1, 16'd125));
    send_item(mk_req(sa, FC_READ_HOLDING, READ_DATA_LEN, 16'hFFFF, 16'd125));
    send_item(mk_req(sa, FC_READ_HOLDING, READ_DATA_LEN, 16'd124, 16'd1));
    drain();

    // random phases over several slave addresses
    write_slave_address(8'h00);
    random_phase(75);
    drain();
    write_slave_address(8'hFF);
    random_phase(75);
    drain();
    write_slave_address(8'($urandom_range(2, 254)));
    random_phase(75);
    drain();

    // last phase runs without idling and starts at the top of the store
    idle_on = 1'b0;
    write_slave_address(SLAVE_ADDR_RST);
    sa = SLAVE_ADDR_RST;
    send_item(mk_load(16'd1023, 16'hA5A5));
    send_item(mk_req(sa, FC_READ_HOLDING, READ_DATA_LEN, 16'd1023, 16'd1));
    send_item(mk_req(sa, FC_READ_HOLDING, READ_DATA_LEN, 16'd1023, 16'd2));
    send_item(mk_req(sa, FC_READ_HOLDING, READ_DATA_LEN, 16'd899, 16'd125));
    random_phase(75);
    drain();

    if (sb.errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

### files.f
design/mbrhs_pkg.sv
design/mbrhs_ram.sv
design/mbrhs_alu.sv
design/modbus_read_holding_slave.sv
tb/modbus_read_holding_slave_tb.sv
